// ===== rtl/core/gtp_pkg.sv =====
package gtp_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned POSITION_WIDTH_DEFAULT = 24;
  localparam int unsigned HEAD_W    = 16;
  localparam int unsigned RANGE_W   = 10;
  localparam int unsigned RADIUS_W  = 16;
  localparam int unsigned SPEED_W   = 12;
  localparam int unsigned TURN_W    = 21;
  localparam int unsigned CFG_IDX_W = 3;

  // Register map of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_X      = 3'd0,
    REG_TARGET_Y      = 3'd1,
    REG_ARRIVE_RADIUS = 3'd2,
    REG_WALL_DISTANCE = 3'd3,
    REG_MIN_SPEED     = 3'd4,
    REG_MAX_SPEED     = 3'd5
  } cfg_reg_e;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd512;
  localparam logic [RANGE_W-1:0]  WALL_RESET   = 10'd10;
  localparam logic [SPEED_W-1:0]  MIN_RESET    = 12'd640;
  localparam logic [SPEED_W-1:0]  MAX_RESET    = 12'd1280;

  // Angle datapath. Angles are carried in 1/256 mrad.
  localparam int unsigned CORDIC_STEPS   = 19;
  localparam int unsigned ANGLE_W        = 22;
  localparam int unsigned PRESCALE_SHIFT = 20;
  localparam int unsigned CORDIC_GUARD   = 3;
  localparam int unsigned BEARING_FRAC   = 8;
  localparam int unsigned BEARING_W      = ANGLE_W - BEARING_FRAC;
  localparam logic signed [ANGLE_W-1:0] HALF_PI_Q8   = 22'sd402124;
  localparam logic signed [ANGLE_W-1:0] BEARING_HALF = 22'sd128;

  localparam logic [17:0] ATAN_Q8 [CORDIC_STEPS] = '{
    18'd201062, 18'd118694, 18'd62715, 18'd31835, 18'd15979, 18'd7997, 18'd4000,
    18'd2000, 18'd1000, 18'd500, 18'd250, 18'd125, 18'd62, 18'd31, 18'd16,
    18'd8, 18'd4, 18'd2, 18'd1
  };

  // Output scaling: divide by five through a reciprocal multiply.
  localparam int unsigned ERR_W           = HEAD_W + 1;
  localparam int unsigned TURN_GAIN_SHIFT = 7;
  localparam int unsigned TURN_BIAS       = 2;
  localparam int unsigned SPEED_BIAS      = 10;
  localparam int unsigned DIV_W           = 32;
  localparam int unsigned PROD_W          = 2 * DIV_W;
  localparam int unsigned RECIP5_SHIFT    = 34;
  localparam int unsigned QUOT_W          = PROD_W - RECIP5_SHIFT;
  localparam logic [DIV_W-1:0] RECIP5     = 32'hCCCC_CCCD;

  typedef struct packed {
    logic [RADIUS_W-1:0] radius;
    logic [RANGE_W-1:0]  wall;
    logic [SPEED_W-1:0]  min_speed;
    logic [SPEED_W-1:0]  max_speed;
  } cfg_t;

  // Per-item side information that rides along the pipeline.
  typedef struct packed {
    logic              zero;
    logic              done;
    logic [HEAD_W-1:0] head;
  } side_t;

  function automatic int unsigned cordic_w(input int unsigned pw);
    return pw + 1 + PRESCALE_SHIFT + CORDIC_GUARD;
  endfunction

  function automatic logic [17:0] atan_q8(input int unsigned i);
    logic [17:0] r;
    r = '0;
    for (int unsigned k = 0; k < CORDIC_STEPS; k++) begin
      if (k == i) begin
        r = ATAN_Q8[k];
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/go_to_point_steering.sv =====
// Go-to-point steering. Each item carries a position estimate, a heading in
// milliradians and a front range reading; the block answers every item with
// exactly one result: a drive speed of 0.05 times the distance to the target
// (rounded, then clamped to the minimum and maximum speed registers, the
// maximum winning when the two cross), a turn rate of -25.6 times the
// difference between the target bearing and the heading (no angle wrap), and
// a finished flag raised inside the arrival radius or when the front range is
// below the wall threshold. The datapath is a fully pipelined chain of
// identical cells: each cell performs at most one CORDIC vectoring rotation
// for the bearing and at most one restoring square-root digit for the exact
// distance, so one item can be accepted on every clock while in_stall_o is
// low. The chain has max(19, POSITION_WIDTH+1) cells. Items flow while the
// output is stalled until a two-entry output stage (output register plus
// skid register) is full; in_stall_o then rises and the whole chain holds.
// Configuration registers may be written only while no item is in flight.
module go_to_point_steering #(
  parameter int unsigned POSITION_WIDTH = gtp_pkg::POSITION_WIDTH_DEFAULT,
  localparam int unsigned CfgW =
      (POSITION_WIDTH > gtp_pkg::RADIUS_W) ? POSITION_WIDTH : gtp_pkg::RADIUS_W
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write port.
  input  logic                                cfg_we_i,
  input  logic [gtp_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [CfgW-1:0]                     cfg_data_i,
  // Input item channel.
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [POSITION_WIDTH-1:0]    pos_x_i,
  input  logic signed [POSITION_WIDTH-1:0]    pos_y_i,
  input  logic signed [gtp_pkg::HEAD_W-1:0]   heading_mrad_i,
  input  logic [gtp_pkg::RANGE_W-1:0]         front_range_i,
  // Result item channel.
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [gtp_pkg::SPEED_W-1:0]         drive_speed_o,
  output logic signed [gtp_pkg::TURN_W-1:0]   turn_rate_o,
  output logic                                finished_o
);
  import gtp_pkg::*;

  localparam int unsigned PW    = POSITION_WIDTH;
  localparam int unsigned CW    = cordic_w(PW);
  localparam int unsigned RadW  = 2 * PW + 2;
  localparam int unsigned RemW  = PW + 3;
  localparam int unsigned RootW = PW + 1;
  localparam int unsigned NCell = (RootW > CORDIC_STEPS) ? RootW : CORDIC_STEPS;

  // ---------------------------------------------------------------------------
  // Configuration registers. Bits above a register's width are dropped and
  // writes to indexes past the register map are ignored.
  // ---------------------------------------------------------------------------
  logic signed [PW-1:0] target_x_q, target_y_q;
  cfg_t                 cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_x_q      <= '0;
      target_y_q      <= '0;
      cfg_q.radius    <= RADIUS_RESET;
      cfg_q.wall      <= WALL_RESET;
      cfg_q.min_speed <= MIN_RESET;
      cfg_q.max_speed <= MAX_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TARGET_X:      target_x_q      <= cfg_data_i[PW-1:0];
        REG_TARGET_Y:      target_y_q      <= cfg_data_i[PW-1:0];
        REG_ARRIVE_RADIUS: cfg_q.radius    <= cfg_data_i[RADIUS_W-1:0];
        REG_WALL_DISTANCE: cfg_q.wall      <= cfg_data_i[RANGE_W-1:0];
        REG_MIN_SPEED:     cfg_q.min_speed <= cfg_data_i[SPEED_W-1:0];
        REG_MAX_SPEED:     cfg_q.max_speed <= cfg_data_i[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline advance. Every stage moves together whenever the skid register is
  // empty; the skid register is the only place a finished result can park, so
  // the stall seen upstream is a plain flop and never a path from out_stall_i.
  // ---------------------------------------------------------------------------
  logic skid_full_q;
  logic en;

  assign en         = !skid_full_q;
  assign in_stall_o = skid_full_q;

  // Front end: offsets, squares, quadrant fold, arrival and wall tests.
  logic                      ch_valid [NCell+1];
  logic signed [CW-1:0]      ch_x     [NCell+1];
  logic signed [CW-1:0]      ch_y     [NCell+1];
  logic signed [ANGLE_W-1:0] ch_z     [NCell+1];
  logic [RadW-1:0]           ch_rad   [NCell+1];
  logic [RemW-1:0]           ch_rem   [NCell+1];
  logic [RootW-1:0]          ch_root  [NCell+1];
  side_t                     ch_side  [NCell+1];

  gtp_front #(
    .POSITION_WIDTH(PW)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .valid_i        (in_valid_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .heading_mrad_i (heading_mrad_i),
    .front_range_i  (front_range_i),
    .target_x_i     (target_x_q),
    .target_y_i     (target_y_q),
    .cfg_i          (cfg_q),
    .valid_o        (ch_valid[0]),
    .x_o            (ch_x[0]),
    .y_o            (ch_y[0]),
    .z_o            (ch_z[0]),
    .rad_o          (ch_rad[0]),
    .side_o         (ch_side[0])
  );

  // The square root starts from an empty remainder and an empty root.
  assign ch_rem[0]  = '0;
  assign ch_root[0] = '0;

  // The cell chain. Cell g does CORDIC rotation g while g is below the
  // rotation count and square-root digit g while g is below the root width;
  // past either count it just forwards that half of the state.
  for (genvar g = 0; g < NCell; g++) begin : g_cell
    gtp_cell #(
      .POSITION_WIDTH(PW),
      .IDX           (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (ch_valid[g]),
      .x_i     (ch_x[g]),
      .y_i     (ch_y[g]),
      .z_i     (ch_z[g]),
      .rad_i   (ch_rad[g]),
      .rem_i   (ch_rem[g]),
      .root_i  (ch_root[g]),
      .side_i  (ch_side[g]),
      .valid_o (ch_valid[g+1]),
      .x_o     (ch_x[g+1]),
      .y_o     (ch_y[g+1]),
      .z_o     (ch_z[g+1]),
      .rad_o   (ch_rad[g+1]),
      .rem_o   (ch_rem[g+1]),
      .root_o  (ch_root[g+1]),
      .side_o  (ch_side[g+1])
    );
  end

  // Back end: bearing rounding, division by five, clamp and sign.
  logic                back_valid;
  logic [SPEED_W-1:0]  back_speed;
  logic [TURN_W-1:0]   back_turn;
  logic                back_done;

  gtp_back #(
    .POSITION_WIDTH(PW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .valid_i       (ch_valid[NCell]),
    .dist_i        (ch_root[NCell]),
    .z_i           (ch_z[NCell]),
    .side_i        (ch_side[NCell]),
    .cfg_i         (cfg_q),
    .valid_o       (back_valid),
    .drive_speed_o (back_speed),
    .turn_rate_o   (back_turn),
    .finished_o    (back_done)
  );

  // ---------------------------------------------------------------------------
  // Output register and skid register. When the output is free (empty or being
  // taken) it reloads from the skid register if that holds an item, otherwise
  // from the back end. When the output is held, an item leaving the back end
  // parks in the skid register, which then freezes the pipeline.
  // ---------------------------------------------------------------------------
  logic               out_valid_q;
  logic               out_take;
  logic [SPEED_W-1:0] out_speed_q, skid_speed_q;
  logic [TURN_W-1:0]  out_turn_q, skid_turn_q;
  logic               out_done_q, skid_done_q;

  assign out_take = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_full_q <= 1'b0;
    end else if (out_take) begin
      if (skid_full_q) begin
        out_valid_q <= 1'b1;
        skid_full_q <= 1'b0;
      end else begin
        out_valid_q <= back_valid;
      end
    end else if (back_valid && !skid_full_q) begin
      skid_full_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take) begin
      if (skid_full_q) begin
        out_speed_q <= skid_speed_q;
        out_turn_q  <= skid_turn_q;
        out_done_q  <= skid_done_q;
      end else if (back_valid) begin
        out_speed_q <= back_speed;
        out_turn_q  <= back_turn;
        out_done_q  <= back_done;
      end
    end else if (back_valid && !skid_full_q) begin
      skid_speed_q <= back_speed;
      skid_turn_q  <= back_turn;
      skid_done_q  <= back_done;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign drive_speed_o = out_speed_q;
  assign turn_rate_o   = out_turn_q;
  assign finished_o    = out_done_q;

endmodule

// ===== rtl/core/gtp_front.sv =====
module gtp_front #(
  parameter int unsigned POSITION_WIDTH = gtp_pkg::POSITION_WIDTH_DEFAULT,
  localparam int unsigned CW = gtp_pkg::cordic_w(POSITION_WIDTH)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic signed [POSITION_WIDTH-1:0]    pos_x_i,
  input  logic signed [POSITION_WIDTH-1:0]    pos_y_i,
  input  logic signed [gtp_pkg::HEAD_W-1:0]   heading_mrad_i,
  input  logic [gtp_pkg::RANGE_W-1:0]         front_range_i,
  input  logic signed [POSITION_WIDTH-1:0]    target_x_i,
  input  logic signed [POSITION_WIDTH-1:0]    target_y_i,
  input  gtp_pkg::cfg_t                       cfg_i,
  output logic                                valid_o,
  output logic signed [CW-1:0]                x_o,
  output logic signed [CW-1:0]                y_o,
  output logic signed [gtp_pkg::ANGLE_W-1:0]  z_o,
  output logic [2*POSITION_WIDTH+1:0]         rad_o,
  output gtp_pkg::side_t                      side_o
);
  import gtp_pkg::*;

  localparam int unsigned PW   = POSITION_WIDTH;
  localparam int unsigned DW   = PW + 1;
  localparam int unsigned SqW  = 2 * PW + 1;
  localparam int unsigned SumW = 2 * PW + 2;
  localparam int unsigned RsqW = 2 * RADIUS_W;
  localparam int unsigned CmpW = (SumW > RsqW) ? SumW : RsqW;
  localparam int unsigned PadW = CW - (DW + 1) - PRESCALE_SHIFT;

  // Stage A: offsets to the target and the wall test.
  logic                 a_valid_q;
  logic signed [DW-1:0] a_dx_d, a_dy_d, a_dx_q, a_dy_q;
  side_t                a_side_d, a_side_q;

  assign a_dx_d = $signed({target_x_i[PW-1], target_x_i}) - $signed({pos_x_i[PW-1], pos_x_i});
  assign a_dy_d = $signed({target_y_i[PW-1], target_y_i}) - $signed({pos_y_i[PW-1], pos_y_i});

  always_comb begin
    a_side_d      = '0;
    a_side_d.done = front_range_i < cfg_i.wall;
    a_side_d.head = heading_mrad_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_dx_q   <= a_dx_d;
      a_dy_q   <= a_dy_d;
      a_side_q <= a_side_d;
    end
  end

  // Stage B: squares, radius squared and the quadrant fold into the right half plane.
  logic                      b_valid_q;
  logic signed [2*DW-1:0]    b_px, b_py;
  logic [SqW-1:0]            b_sqx_q, b_sqy_q;
  logic [RsqW-1:0]           b_rsq_q;
  logic signed [DW:0]        ex, ey, nx, ny, rot_x, rot_y;
  logic signed [ANGLE_W-1:0] b_z_d, b_z_q;
  logic signed [CW-1:0]      b_x_d, b_y_d, b_x_q, b_y_q;
  side_t                     b_side_d, b_side_q;

  assign b_px = a_dx_q * a_dx_q;
  assign b_py = a_dy_q * a_dy_q;

  always_comb begin
    ex = {a_dx_q[DW-1], a_dx_q};
    ey = {a_dy_q[DW-1], a_dy_q};
    nx = -ex;
    ny = -ey;
    if (a_dy_q[DW-1]) begin
      if (!a_dx_q[DW-1]) begin
        rot_x = ex;
        rot_y = ny;
        b_z_d = HALF_PI_Q8;
      end else begin
        rot_x = nx;
        rot_y = ey;
        b_z_d = -HALF_PI_Q8;
      end
    end else begin
      rot_x = ey;
      rot_y = ex;
      b_z_d = '0;
    end
    b_x_d = {{PadW{rot_x[DW]}}, rot_x, {PRESCALE_SHIFT{1'b0}}};
    b_y_d = {{PadW{rot_y[DW]}}, rot_y, {PRESCALE_SHIFT{1'b0}}};
    b_side_d      = a_side_q;
    b_side_d.zero = (a_dx_q == '0) && (a_dy_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (en_i) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_sqx_q  <= b_px[SqW-1:0];
      b_sqy_q  <= b_py[SqW-1:0];
      b_rsq_q  <= cfg_i.radius * cfg_i.radius;
      b_x_q    <= b_x_d;
      b_y_q    <= b_y_d;
      b_z_q    <= b_z_d;
      b_side_q <= b_side_d;
    end
  end

  // Stage C: squared distance and the arrival test.
  logic                      c_valid_q;
  logic [SumW-1:0]           c_sum_d, c_sum_q;
  logic signed [CW-1:0]      c_x_q, c_y_q;
  logic signed [ANGLE_W-1:0] c_z_q;
  side_t                     c_side_d, c_side_q;

  always_comb begin
    c_sum_d       = SumW'(b_sqx_q) + SumW'(b_sqy_q);
    c_side_d      = b_side_q;
    c_side_d.done = b_side_q.done | (CmpW'(c_sum_d) < CmpW'(b_rsq_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (en_i) begin
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_sum_q  <= c_sum_d;
      c_x_q    <= b_x_q;
      c_y_q    <= b_y_q;
      c_z_q    <= b_z_q;
      c_side_q <= c_side_d;
    end
  end

  assign valid_o = c_valid_q;
  assign x_o     = c_x_q;
  assign y_o     = c_y_q;
  assign z_o     = c_z_q;
  assign rad_o   = c_sum_q;
  assign side_o  = c_side_q;

endmodule

// ===== rtl/core/gtp_cell.sv =====
module gtp_cell #(
  parameter int unsigned POSITION_WIDTH = gtp_pkg::POSITION_WIDTH_DEFAULT,
  parameter int unsigned IDX = 0,
  localparam int unsigned CW = gtp_pkg::cordic_w(POSITION_WIDTH)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic signed [CW-1:0]                x_i,
  input  logic signed [CW-1:0]                y_i,
  input  logic signed [gtp_pkg::ANGLE_W-1:0]  z_i,
  input  logic [2*POSITION_WIDTH+1:0]         rad_i,
  input  logic [POSITION_WIDTH+2:0]           rem_i,
  input  logic [POSITION_WIDTH:0]             root_i,
  input  gtp_pkg::side_t                      side_i,
  output logic                                valid_o,
  output logic signed [CW-1:0]                x_o,
  output logic signed [CW-1:0]                y_o,
  output logic signed [gtp_pkg::ANGLE_W-1:0]  z_o,
  output logic [2*POSITION_WIDTH+1:0]         rad_o,
  output logic [POSITION_WIDTH+2:0]           rem_o,
  output logic [POSITION_WIDTH:0]             root_o,
  output gtp_pkg::side_t                      side_o
);
  import gtp_pkg::*;

  localparam int unsigned RadW  = 2 * POSITION_WIDTH + 2;
  localparam int unsigned RemW  = POSITION_WIDTH + 3;
  localparam int unsigned RootW = POSITION_WIDTH + 1;
  localparam bit DoCordic = IDX < CORDIC_STEPS;
  localparam bit DoRoot   = IDX < RootW;
  localparam logic signed [ANGLE_W-1:0] AtanZ = ANGLE_W'(atan_q8(IDX));

  logic signed [CW-1:0]      xs, ys, x_d, y_d;
  logic signed [ANGLE_W-1:0] z_d;
  logic [RemW-1:0]           rem_t, trial, rem_d;
  logic [RootW-1:0]          root_d;
  logic [RadW-1:0]           rad_d;
  logic                      ge;

  // One CORDIC vectoring micro-rotation: drive y toward zero.
  always_comb begin
    xs = x_i >>> IDX;
    ys = y_i >>> IDX;
    if (DoCordic) begin
      if (!y_i[CW-1] && (y_i != '0)) begin
        x_d = x_i + ys;
        y_d = y_i - xs;
        z_d = z_i + AtanZ;
      end else begin
        x_d = x_i - ys;
        y_d = y_i + xs;
        z_d = z_i - AtanZ;
      end
    end else begin
      x_d = x_i;
      y_d = y_i;
      z_d = z_i;
    end
  end

  // One restoring square-root digit: bring down two radicand bits, try root*4+1.
  always_comb begin
    rem_t = {rem_i[RootW-1:0], rad_i[RadW-1 -: 2]};
    trial = {root_i, 2'b01};
    ge    = rem_t >= trial;
    if (DoRoot) begin
      rem_d  = ge ? (rem_t - trial) : rem_t;
      root_d = {root_i[RootW-2:0], ge};
      rad_d  = {rad_i[RadW-3:0], 2'b00};
    end else begin
      rem_d  = rem_i;
      root_d = root_i;
      rad_d  = rad_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_o    <= x_d;
      y_o    <= y_d;
      z_o    <= z_d;
      rad_o  <= rad_d;
      rem_o  <= rem_d;
      root_o <= root_d;
      side_o <= side_i;
    end
  end

endmodule

// ===== rtl/core/gtp_back.sv =====
module gtp_back #(
  parameter int unsigned POSITION_WIDTH = gtp_pkg::POSITION_WIDTH_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic [POSITION_WIDTH:0]             dist_i,
  input  logic signed [gtp_pkg::ANGLE_W-1:0]  z_i,
  input  gtp_pkg::side_t                      side_i,
  input  gtp_pkg::cfg_t                       cfg_i,
  output logic                                valid_o,
  output logic [gtp_pkg::SPEED_W-1:0]         drive_speed_o,
  output logic signed [gtp_pkg::TURN_W-1:0]   turn_rate_o,
  output logic                                finished_o
);
  import gtp_pkg::*;

  localparam int unsigned NumW = POSITION_WIDTH + 2;
  localparam int unsigned MW   = POSITION_WIDTH;
  localparam int unsigned MagW = ERR_W + TURN_GAIN_SHIFT;

  // Stage P: rounded bearing, heading error and speed numerator.
  logic                        p_valid_q, p_done_q;
  logic signed [ANGLE_W-1:0]   z_round;
  logic signed [BEARING_W-1:0] bearing;
  logic signed [ERR_W-1:0]     p_err_d, p_err_q;
  logic [NumW-1:0]             spd_num;
  logic [MW-1:0]               p_m_q;

  always_comb begin
    z_round = z_i + BEARING_HALF;
    bearing = side_i.zero ? '0 : z_round[ANGLE_W-1:BEARING_FRAC];
    p_err_d = $signed({{(ERR_W-BEARING_W){bearing[BEARING_W-1]}}, bearing})
            - $signed({side_i.head[HEAD_W-1], side_i.head});
    spd_num = NumW'(dist_i) + NumW'(SPEED_BIAS);
  end

  // Stage Q: error magnitude scaled by 128 with the rounding bias.
  logic               q_valid_q, q_done_q, q_flip_q;
  logic [ERR_W-1:0]   mag;
  logic [MagW-1:0]    q_tn_d, q_tn_q;
  logic [MW-1:0]      q_m_q;

  always_comb begin
    mag    = p_err_q[ERR_W-1] ? ERR_W'(-p_err_q) : ERR_W'(p_err_q);
    q_tn_d = {mag, {TURN_GAIN_SHIFT{1'b0}}} + MagW'(TURN_BIAS);
  end

  // Stage R: both divisions by five.
  logic               r_valid_q, r_done_q, r_flip_q;
  logic [PROD_W-1:0]  prod_spd, prod_turn;
  logic [QUOT_W-1:0]  r_spd_q;
  logic [TURN_W-1:0]  r_turn_q;

  assign prod_spd  = PROD_W'(q_m_q) * PROD_W'(RECIP5);
  assign prod_turn = PROD_W'(q_tn_q) * PROD_W'(RECIP5);

  // Stage S: clamp (maximum applied last so it wins) and sign of the turn.
  logic [QUOT_W-1:0]  lo;
  logic [SPEED_W-1:0] s_spd_d;
  logic [TURN_W-1:0]  s_turn_d;

  always_comb begin
    lo       = (r_spd_q < QUOT_W'(cfg_i.min_speed)) ? QUOT_W'(cfg_i.min_speed) : r_spd_q;
    s_spd_d  = (lo > QUOT_W'(cfg_i.max_speed)) ? cfg_i.max_speed : lo[SPEED_W-1:0];
    s_turn_d = r_flip_q ? (-r_turn_q) : r_turn_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      q_valid_q <= 1'b0;
      r_valid_q <= 1'b0;
      valid_o   <= 1'b0;
    end else if (en_i) begin
      p_valid_q <= valid_i;
      q_valid_q <= p_valid_q;
      r_valid_q <= q_valid_q;
      valid_o   <= r_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_err_q       <= p_err_d;
      p_m_q         <= spd_num[NumW-1:2];
      p_done_q      <= side_i.done;
      q_tn_q        <= q_tn_d;
      q_m_q         <= p_m_q;
      q_flip_q      <= !p_err_q[ERR_W-1] && (p_err_q != '0);
      q_done_q      <= p_done_q;
      r_spd_q       <= prod_spd[PROD_W-1:RECIP5_SHIFT];
      r_turn_q      <= prod_turn[RECIP5_SHIFT +: TURN_W];
      r_flip_q      <= q_flip_q;
      r_done_q      <= q_done_q;
      drive_speed_o <= s_spd_d;
      turn_rate_o   <= s_turn_d;
      finished_o    <= r_done_q;
    end
  end

endmodule
